// ----- src/sorted_set_insert_remove_unit_defines.svh -----
// Assertion helpers for the RTL; they expect clk and rst_n in scope.
`ifndef SORTED_SET_INSERT_REMOVE_UNIT_DEFINES_SVH
`define SORTED_SET_INSERT_REMOVE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SSIR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SSIR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ssir_pkg.sv -----
package ssir_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 5;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_REMOVED   = 3'd1,
        STAT_DUPLICATE = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4
    } ssir_status_t;

    // Broadcast from the sequencer to every cell in the row.
    typedef struct packed {
        logic                       cmp_en;
        logic                       ins_en;
        logic                       rem_en;
        logic signed [VALUE_W-1:0]  key;
    } ssir_ctrl_t;

endpackage

// ----- src/sorted_set_insert_remove_unit.sv -----
// Each accepted request steps through S_CMP and S_APPLY, then done pulses.
// No new request is taken while busy; busy stays high for the compare
// cycle (every cell registers its less-than and equal flags against the key)
// and the apply cycle (cells shift in place and the result is registered).
// done is a single-cycle strobe; the receiver has no way to stall it.
// Reset clears the entry count, all cell valid flags and the sequencer.
`include "sorted_set_insert_remove_unit_defines.svh"

module sorted_set_insert_remove_unit
    import ssir_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       req_type,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       done,
    output logic [STATUS_W-1:0]        status,
    output logic [COUNT_W-1:0]         entry_count
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic                      req_reg;
    logic                      req_next;
    logic signed [VALUE_W-1:0] key_reg;
    logic signed [VALUE_W-1:0] key_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      done_reg;
    logic                      done_next;
    ssir_status_t              status_reg;
    ssir_status_t              status_next;

    ssir_ctrl_t                ctrl;
    logic                      present;
    logic                      full;

    logic signed [VALUE_W-1:0] val_vec [CAPACITY];
    logic [CAPACITY-1:0]       vld_vec;
    logic [CAPACITY-1:0]       lt_vec;
    logic [CAPACITY-1:0]       eq_vec;
    logic [CNT_W+COUNT_W-1:0]  count_wide;

    assign present = |eq_vec;
    assign full    = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        ctrl.cmp_en = (state_reg == S_CMP);
        ctrl.ins_en = (state_reg == S_APPLY) && !req_reg && !present && !full;
        ctrl.rem_en = (state_reg == S_APPLY) && req_reg && present;
        ctrl.key    = key_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [VALUE_W-1:0] lval;
            logic                      lvld;
            logic                      llt;
            logic signed [VALUE_W-1:0] rval;
            logic                      rvld;

            if (gi == 0)
            begin : g_first
                assign lval = '0;
                assign lvld = 1'b0;
                assign llt  = 1'b1;
            end
            else
            begin : g_mid_l
                assign lval = val_vec[gi-1];
                assign lvld = vld_vec[gi-1];
                assign llt  = lt_vec[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign rval = '0;
                assign rvld = 1'b0;
            end
            else
            begin : g_mid_r
                assign rval = val_vec[gi+1];
                assign rvld = vld_vec[gi+1];
            end

            ssir_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_value  (lval),
                .left_valid  (lvld),
                .left_lt     (llt),
                .right_value (rval),
                .right_valid (rvld),
                .cell_value  (val_vec[gi]),
                .cell_valid  (vld_vec[gi]),
                .lt_flag     (lt_vec[gi]),
                .eq_flag     (eq_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req_type;
                    key_next   = value;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (!req_reg)
                begin
                    if (present)
                        status_next = STAT_DUPLICATE;
                    else if (full)
                        status_next = STAT_FULL;
                    else
                    begin
                        status_next = STAT_INSERTED;
                        count_next  = count_reg + 1'b1;
                    end
                end
                else
                begin
                    if (present)
                    begin
                        status_next = STAT_REMOVED;
                        count_next  = count_reg - 1'b1;
                    end
                    else
                        status_next = STAT_NOT_FOUND;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            req_reg    <= 1'b0;
            key_reg    <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= STAT_INSERTED;
        end
        else
        begin
            state_reg  <= state_next;
            req_reg    <= req_next;
            key_reg    <= key_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    assign count_wide  = {{COUNT_W{1'b0}}, count_reg};
    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_count = count_wide[COUNT_W-1:0];

    `SSIR_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `SSIR_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
    `SSIR_ASSERT_IMP(a_ins_count, done && (status_reg == STAT_INSERTED), count_reg == $past(count_reg) + 1'b1, "insert did not bump count")
    `SSIR_ASSERT_IMP(a_valid_prefix, 1'b1, vld_vec[0] == (count_reg != '0), "slot 0 valid disagrees with count")

endmodule

// ----- src/ssir_cell.sv -----
module ssir_cell
    import ssir_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ssir_ctrl_t                ctrl,
    input  logic signed [VALUE_W-1:0] left_value,
    input  logic                      left_valid,
    input  logic                      left_lt,
    input  logic signed [VALUE_W-1:0] right_value,
    input  logic                      right_valid,
    output logic signed [VALUE_W-1:0] cell_value,
    output logic                      cell_valid,
    output logic                      lt_flag,
    output logic                      eq_flag
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      lt_reg;
    logic                      lt_next;
    logic                      eq_reg;
    logic                      eq_next;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        if (ctrl.cmp_en)
        begin
            lt_next = valid_reg && (value_reg < ctrl.key);
            eq_next = valid_reg && (value_reg == ctrl.key);
        end
        if (ctrl.ins_en && !lt_reg)
        begin
            // First slot not below the key takes it; the rest move up one.
            if (left_lt)
            begin
                value_next = ctrl.key;
                valid_next = 1'b1;
            end
            else
            begin
                value_next = left_value;
                valid_next = left_valid;
            end
        end
        else if (ctrl.rem_en && !lt_reg)
        begin
            // Close up from the right, dropping the matched entry.
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
        end
    end

    assign cell_value = value_reg;
    assign cell_valid = valid_reg;
    assign lt_flag    = lt_reg;
    assign eq_flag    = eq_reg;

endmodule
